// ===== rtl/lr_pkg.sv =====
package lr_pkg;

    // Default coordinate width of the segment end points and pixels.
    localparam int LR_COORD_BITS = 6;

    // Segment descriptors held between classification and the walker.
    localparam int LR_QUEUE_DEPTH = 2;

    // Error-term width. Steep segments keep adding 2*(dy - dx) once per column, so the
    // term climbs to about 2^(2*coord_bits - 1); one more bit holds the sign.
    function automatic int lr_err_bits(input int coord_bits);
        return 2 * coord_bits + 1;
    endfunction

    // Width of one classified segment descriptor for a given coordinate width.
    function automatic int lr_desc_bits(input int coord_bits);
        return 5 * coord_bits + 1 + lr_err_bits(coord_bits);
    endfunction

endpackage

// ===== rtl/lr_front.sv =====
module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [COORD_BITS-1:0]               i_start_x,
    input  logic [COORD_BITS-1:0]               i_start_y,
    input  logic [COORD_BITS-1:0]               i_end_x,
    input  logic [COORD_BITS-1:0]               i_end_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lr_desc_bits(COORD_BITS)-1:0] o_desc
);

    localparam int EW     = lr_err_bits(COORD_BITS);
    localparam int DESC_W = lr_desc_bits(COORD_BITS);

    logic                    r_valid;
    logic                    n_valid;
    logic [DESC_W-1:0]       r_desc;
    logic                    step_down;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic signed [EW-1:0]    err_init;
    logic                    accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_desc  = r_desc;

    // dx only matters when the end lies right of the start, so wrap is harmless.
    always_comb begin
        step_down = (i_end_y < i_start_y);
        dx        = i_end_x - i_start_x;
        dy        = step_down ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        err_init  = signed'(EW'({dy, 1'b0})) - signed'(EW'(dx));
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= {i_start_x, i_start_y, i_end_x, dx, dy, step_down, err_init};
        end
    end

endmodule

// ===== rtl/lr_queue.sv =====
module lr_queue
    import lr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LR_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_count;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
        return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lr_walker.sv =====
module lr_walker
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lr_desc_bits(COORD_BITS)-1:0] i_desc,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [COORD_BITS-1:0]               o_pixel_x,
    output logic [COORD_BITS-1:0]               o_pixel_y,
    output logic                                o_last_pixel
);

    localparam int EW = lr_err_bits(COORD_BITS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                  r_state;
    logic                  n_state;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [COORD_BITS-1:0] r_stop_x;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic                  r_step_down;
    logic signed [EW-1:0]  r_err;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic                  r_out_last;

    logic [COORD_BITS-1:0] d_start_x;
    logic [COORD_BITS-1:0] d_start_y;
    logic [COORD_BITS-1:0] d_end_x;
    logic [COORD_BITS-1:0] d_dx;
    logic [COORD_BITS-1:0] d_dy;
    logic                  d_step_down;
    logic signed [EW-1:0]  d_err;

    logic                  load;
    logic                  emit;
    logic                  at_end;
    logic signed [EW-1:0]  dy2;
    logic signed [EW-1:0]  diag2;
    logic                  err_pos;

    assign {d_start_x, d_start_y, d_end_x, d_dx, d_dy, d_step_down, d_err} = i_desc;

    assign o_ready      = (r_state == ST_IDLE);
    assign load         = i_valid && o_ready;
    assign emit         = (r_state == ST_WALK) && (!r_out_valid || i_ready);
    assign at_end       = (r_cur_x >= r_stop_x);
    assign dy2          = signed'(EW'({r_dy, 1'b0}));
    assign diag2        = dy2 - signed'(EW'({r_dx, 1'b0}));
    assign err_pos      = !r_err[EW-1] && (r_err != '0);

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_last_pixel = r_out_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (emit && at_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur_x     <= d_start_x;
            r_cur_y     <= d_start_y;
            r_stop_x    <= d_end_x;
            r_dx        <= d_dx;
            r_dy        <= d_dy;
            r_step_down <= d_step_down;
            r_err       <= d_err;
        end else if (emit && !at_end) begin
            // advance one column; y moves toward the end row on a positive error
            r_cur_x <= r_cur_x + 1'b1;
            if (err_pos) begin
                r_err   <= r_err + diag2;
                r_cur_y <= r_step_down ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end else begin
                r_err <= r_err + dy2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_last <= at_end;
        end
    end

endmodule

// ===== rtl/line_rasterizer_unit.sv =====
// Midpoint line rasterizer.
// Input channel (i_valid / o_ready): one segment per beat, given by its start
// and end grid coordinates. Output channel (o_valid / i_ready): one pixel per
// beat, from the start point column by column up to the end column, with
// o_last_pixel high on the final pixel. A segment whose end column is not right
// of its start column yields just the start pixel, marked last.
// Segments are classified on entry and held in a two-deep queue, so up to
// three segments are taken while the walker is still busy.
// On its way out a segment passes the front register, the queue, the walker's
// state registers and the output register. The walker emits one pixel per
// cycle while i_ready is high, and it loads a segment only when idle, that is
// after the last pixel of the previous segment has been emitted.
// Reset (synchronous, active low) empties the queue and the output register
// and drops any segment in progress.
// When the receiver holds i_ready low the current pixel stays on the output
// and the walk pauses; the queue then fills and o_ready drops.
module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    localparam int DESC_W = lr_desc_bits(COORD_BITS);
    localparam int LVL_W  = $clog2(LR_QUEUE_DEPTH + 1);

    logic              front_valid;
    logic              front_ready;
    logic [DESC_W-1:0] front_desc;
    logic              queue_valid;
    logic              queue_ready;
    logic [DESC_W-1:0] queue_desc;
    logic [LVL_W-1:0]  queue_level;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_valid   (front_valid),
        .i_ready   (front_ready),
        .o_desc    (front_desc)
    );

    lr_queue #(
        .WIDTH (DESC_W),
        .DEPTH (LR_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_desc),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_data  (queue_desc),
        .o_level (queue_level)
    );

    lr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .o_ready      (queue_ready),
        .i_desc       (queue_desc),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    // Queue never holds more than its depth.
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_level <= LVL_W'(LR_QUEUE_DEPTH))
        else $error("segment queue overfilled");

    // Within a segment the next pixel follows at once, one column to the right.
    a_next_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_pixel) |=>
            (o_valid && o_pixel_x == COORD_BITS'($past(o_pixel_x) + 1'b1)))
        else $error("pixel walk skipped or stalled a column");

    // Within a segment the row moves by at most one per column.
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_pixel) |=>
            (o_pixel_y == $past(o_pixel_y) ||
             o_pixel_y == COORD_BITS'($past(o_pixel_y) + 1'b1) ||
             o_pixel_y == COORD_BITS'($past(o_pixel_y) - 1'b1)))
        else $error("pixel row jumped by more than one");

    // After taking a segment the walker must not sit idle with no pixel on the output.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (queue_valid && queue_ready) |=> !(queue_ready && !o_valid && !$past(o_valid)))
        else $error("walker idle after taking a segment");

endmodule

// ===== tb/sv/line_rasterizer_checker.sv =====
module line_rasterizer_checker
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_seg_valid,
    input  logic                  i_seg_ready,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic                  i_last_pixel,
    output int                    o_fail_count,
    output int                    o_pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ERR_W = lr_err_bits(COORD_BITS);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    t_pixel pixel_queue[$];
    int     fail_total = 0;
    int     pending_total = 0;

    // Walker state, kept between segments like the block's own registers.
    logic signed [ERR_W-1:0] walk_err = '0;
    t_coord                  walk_x = '0;
    t_coord                  walk_y = '0;
    t_coord                  walk_stop = '0;
    logic                    walk_down = 1'b0;

    assign o_fail_count     = fail_total;
    assign o_pixels_pending = pending_total;

    task automatic push_pixel(input logic last);
        t_pixel beat;
        beat.x    = walk_x;
        beat.y    = walk_y;
        beat.last = last;
        pixel_queue.insert(pixel_queue.size(), beat);
    endtask

    task automatic walk_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        logic signed [ERR_W-1:0] dx;
        logic signed [ERR_W-1:0] dy;
        walk_x    = sx;
        walk_y    = sy;
        walk_stop = ex;
        walk_down = (ey < sy);
        dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
        dy = walk_down ? ($signed({1'b0, sy}) - $signed({1'b0, ey}))
                       : ($signed({1'b0, ey}) - $signed({1'b0, sy}));
        walk_err = (dy <<< 1) - dx;
        // end column not right of the start: lone start pixel
        if (walk_x >= walk_stop) begin
            push_pixel(1'b1);
            return;
        end
        push_pixel(1'b0);
        while (walk_x < walk_stop) begin
            if (walk_err <= 0) begin
                walk_err = walk_err + (dy <<< 1);
            end else begin
                walk_err = walk_err + ((dy - dx) <<< 1);
                walk_y   = walk_down ? walk_y - 1'b1 : walk_y + 1'b1;
            end
            walk_x = walk_x + 1'b1;
            push_pixel(walk_x >= walk_stop);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            pixel_queue.delete();
            walk_err  <= '0;
            walk_x    <= '0;
            walk_y    <= '0;
            walk_stop <= '0;
            walk_down <= 1'b0;
        end else begin
            // compare first: a pixel leaving now never belongs to a segment entering now
            if (i_pix_valid && i_pix_ready) begin
                if (pixel_queue.size() == 0) begin
                    fail_total++;
                    $display("%0t: pixel beat with none expected: x=%0d y=%0d last=%0b",
                             $time, i_pixel_x, i_pixel_y, i_last_pixel);
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_pixel_x !== want.x) begin
                        fail_total++;
                        $display("%0t: pixel_x expected %0d actual %0d",
                                 $time, want.x, i_pixel_x);
                    end
                    if (i_pixel_y !== want.y) begin
                        fail_total++;
                        $display("%0t: pixel_y expected %0d actual %0d",
                                 $time, want.y, i_pixel_y);
                    end
                    if (i_last_pixel !== want.last) begin
                        fail_total++;
                        $display("%0t: last_pixel expected %0b actual %0b",
                                 $time, want.last, i_last_pixel);
                    end
                end
            end
            if (i_seg_valid && i_seg_ready) begin
                walk_segment(i_start_x, i_start_y, i_end_x, i_end_y);
            end
        end
        pending_total = pixel_queue.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lr_pkg::*;

    localparam int CB          = LR_COORD_BITS;
    localparam int RANDOM_SEGS = 300;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic [CB-1:0] t_coord;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_start_x;
    t_coord i_start_y;
    t_coord i_end_x;
    t_coord i_end_y;
    logic   o_valid;
    logic   i_ready;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_last_pixel;

    int fail_count;
    int pixels_pending;

    // knobs that steer the segment and pixel sides
    bit seg_gaps = 1'b0;
    bit pix_stalls = 1'b0;
    bit long_hold_req = 1'b0;

    line_rasterizer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last_pixel(o_last_pixel)
    );

    line_rasterizer_checker u_line_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seg_valid     (i_valid),
        .i_seg_ready     (o_ready),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_pix_valid     (o_valid),
        .i_pix_ready     (i_ready),
        .i_pixel_x       (o_pixel_x),
        .i_pixel_y       (o_pixel_y),
        .i_last_pixel    (o_last_pixel),
        .o_fail_count    (fail_count),
        .o_pixels_pending(pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Pixel side: random stall bursts, plus one long hold on request.
    initial begin
        int burst;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (pix_stalls && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
                i_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        int gap;
        if (seg_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random_segment();
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        int     pick;
        int     span;
        int     rise;
        pick = $urandom_range(0, 19);
        sx = t_coord'($urandom_range(0, 63));
        sy = t_coord'($urandom_range(0, 63));
        ex = t_coord'($urandom_range(0, 63));
        ey = t_coord'($urandom_range(0, 63));
        if (pick < 12) begin
            // short walk, shallow or steep either way
            span = $urandom_range(1, 8);
            rise = $urandom_range(0, 12);
            ex = (sx + span > 63) ? t_coord'(63) : t_coord'(sx + span);
            if ($urandom_range(0, 1))
                ey = (sy + rise > 63) ? t_coord'(63) : t_coord'(sy + rise);
            else
                ey = (sy < rise) ? t_coord'(0) : t_coord'(sy - rise);
        end else if (pick >= 17) begin
            // end column at or left of the start
            ex = t_coord'($urandom_range(0, sx));
        end
        send_segment(sx, sy, ex, ey);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x   = '0;
        i_end_y   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed segments
        send_segment(6'd0, 6'd0, 6'd63, 6'd63);
        send_segment(6'd0, 6'd63, 6'd63, 6'd0);
        send_segment(6'd0, 6'd0, 6'd63, 6'd0);
        send_segment(6'd0, 6'd63, 6'd63, 6'd63);
        send_segment(6'd63, 6'd63, 6'd0, 6'd0);
        send_segment(6'd10, 6'd10, 6'd10, 6'd50);
        send_segment(6'd0, 6'd0, 6'd0, 6'd0);
        send_segment(6'd63, 6'd0, 6'd63, 6'd63);
        send_segment(6'd0, 6'd0, 6'd1, 6'd0);
        send_segment(6'd62, 6'd63, 6'd63, 6'd62);
        send_segment(6'd5, 6'd5, 6'd10, 6'd40);
        send_segment(6'd5, 6'd40, 6'd10, 6'd5);
        send_segment(6'd62, 6'd0, 6'd63, 6'd63);
        send_segment(6'd0, 6'd32, 6'd63, 6'd33);
        send_segment(6'd0, 6'd33, 6'd63, 6'd32);
        send_segment(6'd0, 6'd0, 6'd63, 6'd1);
        send_segment(6'd20, 6'd20, 6'd40, 6'd30);
        send_segment(6'd20, 6'd30, 6'd40, 6'd20);
        send_segment(6'd1, 6'd62, 6'd62, 6'd1);
        send_segment(6'd42, 6'd21, 6'd21, 6'd42);

        // both sides idling; partway in, hold the pixel side while segments pile up
        seg_gaps   = 1'b1;
        pix_stalls = 1'b1;
        for (int n = 0; n < 100; n++) begin
            if (n == 40) begin
                seg_gaps      = 1'b0;
                long_hold_req = 1'b1;
            end
            if (n == 60) seg_gaps = 1'b1;
            send_random_segment();
        end

        // pause the segment side until every pixel is out
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pixels_pending == 0);

        seg_gaps = 1'b0;
        for (int n = 0; n < 80; n++) send_random_segment();

        seg_gaps   = 1'b1;
        pix_stalls = 1'b0;
        for (int n = 0; n < 60; n++) send_random_segment();

        // closing stretch at full rate
        seg_gaps = 1'b0;
        for (int n = 0; n < RANDOM_SEGS - 240; n++) send_random_segment();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lr_pkg.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_walker.sv
rtl/line_rasterizer_unit.sv
tb/sv/line_rasterizer_checker.sv
tb/sv/tb_top.sv
